// ----- rtl/dscq_pkg.sv -----
// package for the delayed state change qualifier
// beat types, operation codes, controller state and command/status structs
// no dependencies
`default_nettype none

package dscq_pkg;

   localparam int MAX_CHANNELS     = 16;
   localparam int CHANNELS_DEFAULT = 16;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_RESCAN = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [3:0]  channel;
      logic [7:0]  new_state;
      logic [15:0] action_delay;
      logic [15:0] rescan_mask;
   } dscq_req_type;

   typedef struct packed {
      logic [3:0] out_channel;
      logic [7:0] out_state;
      logic       is_rescan;
      logic       last;
   } dscq_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } dscq_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request beat
      logic sample_go;  // run read-modify-write of the sampled channel
      logic scan_emit;  // announce the current scan channel
      logic scan_next;  // advance the scan index
   } dscq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_rescan;  // request beat carries a rescan
      logic mask_empty;  // no scan channels left
      logic scan_hit;    // current scan channel is selected
      logic out_free;    // output register can take a beat
   } dscq_sts_type;

endpackage

`default_nettype wire

// ----- rtl/dscq_ctrl.sv -----
// controller of the delayed state change qualifier
// depends on dscq_pkg
`default_nettype none

module dscq_ctrl import dscq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire dscq_sts_type sts,
   output dscq_cmd_type      cmd
);

   dscq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.req_rescan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.sample_go = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (sts.mask_empty) begin
               state_in = ST_IDLE;
            end else if (!sts.scan_hit) begin
               cmd.scan_next = 1'b1;
            end else if (sts.out_free) begin
               cmd.scan_emit = 1'b1;
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/dscq_dp.sv -----
// datapath of the delayed state change qualifier
// per-channel state registers, scan walker and output register; depends on dscq_pkg
`default_nettype none

module dscq_dp import dscq_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dscq_req_type req_data,
   input  wire dscq_cmd_type cmd,
   output dscq_sts_type      sts,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output dscq_rsp_type      rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // captured request
   logic [IDX_W-1:0]    chan_ff, chan_in;
   logic [7:0]          nstate_ff, nstate_in;
   logic [15:0]         delay_ff, delay_in;
   logic                range_ok_ff, range_ok_in;
   logic [CHANNELS-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;

   // per-channel state
   logic [7:0]          pub_ff  [CHANNELS];
   logic [7:0]          pub_in  [CHANNELS];
   logic [7:0]          pend_ff [CHANNELS];
   logic [7:0]          pend_in [CHANNELS];
   logic [15:0]         tmr_ff  [CHANNELS];
   logic [15:0]         tmr_in  [CHANNELS];
   logic [CHANNELS-1:0] started_ff, started_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   dscq_rsp_type        rsp_data_ff, rsp_data_in;

   logic [7:0]          cur_pub, cur_pend;
   logic [15:0]         cur_tmr;
   logic                cur_started;
   logic                need_update;
   logic [CHANNELS-1:0] scan_sel;

   assign cur_pub     = pub_ff[chan_ff];
   assign cur_pend    = pend_ff[chan_ff];
   assign cur_tmr     = tmr_ff[chan_ff];
   assign cur_started = started_ff[chan_ff];

   assign need_update = !cur_started ||
                        ((cur_tmr == 16'd0) ? (cur_pub != nstate_ff) : (cur_pend != nstate_ff));

   assign scan_sel = CHANNELS'(1) << scan_idx_ff;

   assign sts.req_rescan = (req_data.operation == OP_RESCAN);
   assign sts.mask_empty = (mask_ff == '0);
   assign sts.scan_hit   = mask_ff[scan_idx_ff];
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      chan_in     = chan_ff;
      nstate_in   = nstate_ff;
      delay_in    = delay_ff;
      range_ok_in = range_ok_ff;
      mask_in     = mask_ff;
      scan_idx_in = scan_idx_ff;
      pub_in      = pub_ff;
      pend_in     = pend_ff;
      tmr_in      = tmr_ff;
      started_in  = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         chan_in     = req_data.channel[IDX_W-1:0];
         nstate_in   = req_data.new_state;
         delay_in    = req_data.action_delay;
         range_ok_in = (32'(req_data.channel) < CHANNELS);
         mask_in     = req_data.rescan_mask[CHANNELS-1:0];
         scan_idx_in = '0;
      end

      if (cmd.sample_go && range_ok_ff) begin
         started_in[chan_ff] = 1'b1;
         if (need_update) begin
            tmr_in[chan_ff] = delay_ff;
            if (delay_ff == 16'd0) begin
               pub_in[chan_ff]         = nstate_ff;
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_channel = 4'(chan_ff);
               rsp_data_in.out_state   = nstate_ff;
               rsp_data_in.is_rescan   = 1'b0;
               rsp_data_in.last        = 1'b1;
            end else begin
               pend_in[chan_ff] = nstate_ff;
            end
         end else if (cur_tmr != 16'd0) begin
            // pending state confirmed again: count down
            tmr_in[chan_ff] = cur_tmr - 16'd1;
            if (cur_tmr == 16'd1) begin
               pub_in[chan_ff]         = nstate_ff;
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_channel = 4'(chan_ff);
               rsp_data_in.out_state   = nstate_ff;
               rsp_data_in.is_rescan   = 1'b0;
               rsp_data_in.last        = 1'b1;
            end
         end
      end

      if (cmd.scan_emit) begin
         mask_in                 = mask_ff & ~scan_sel;
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_channel = 4'(scan_idx_ff);
         rsp_data_in.out_state   = pub_ff[scan_idx_ff];
         rsp_data_in.is_rescan   = 1'b1;
         rsp_data_in.last        = ((mask_ff & ~scan_sel) == '0);
      end

      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pub_ff[i]  <= '0;
            pend_ff[i] <= '0;
            tmr_ff[i]  <= '0;
         end
         started_ff   <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pub_ff       <= pub_in;
         pend_ff      <= pend_in;
         tmr_ff       <= tmr_in;
         started_ff   <= started_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      nstate_ff   <= nstate_in;
      delay_ff    <= delay_in;
      range_ok_ff <= range_ok_in;
      scan_idx_ff <= scan_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/delayed_state_change_qualifier.sv -----
// delayed state change qualifier: per-channel debounce with action delay
// top level joining dscq_ctrl and dscq_dp; depends on dscq_pkg
//
// usage
//   req channel: one beat is a sample (channel, thresholded state, action
//   delay) or a rescan (channel mask), taken when req_valid is high and
//   req_stall is low.
//   rsp channel: announcements (channel, published state, rescan flag, last
//   flag). last marks the final beat caused by one request beat.
//   sequence: a sample is captured, then a read-modify-write of the
//   channel's state registers runs; its announcement, if any, is written
//   to the output register by that read-modify-write. a rescan walks the
//   mask one channel per cycle, a selected channel waiting for a free
//   output register, and returns to idle once it sees the mask empty.
//   stall: the output register holds its beat while rsp_stall is high; a
//   sample's read-modify-write and each rescan announcement wait for a free
//   output register.
//   reset: synchronous, active high; clears all channel state (published,
//   pending, timer, started) and drops any beat in the output register.
//   the block can take a request beat as soon as reset is released.
`default_nettype none

module delayed_state_change_qualifier import dscq_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire dscq_req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output dscq_rsp_type      rsp_data
);

   // command and status between controller and datapath
   dscq_cmd_type cmd;
   dscq_sts_type sts;

   // controller: idle / sample read-modify-write / mask scan
   dscq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: channel state, scan walker, output register
   dscq_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- bench/delayed_state_change_qualifier_tb.sv -----
// testbench for the delayed state change qualifier: directed then random sample and
// rescan beats, checked against a per-channel state predictor kept in the bench
// depends on dscq_pkg and delayed_state_change_qualifier
`timescale 1ns / 100ps

module delayed_state_change_qualifier_tb;
   import dscq_pkg::*;

   localparam int CHANNELS     = CHANNELS_DEFAULT;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_WAIT     = 17;
   // longest quiet stretch of a correct run: request gap, a full 16 channel walk,
   // a receiver stall, taken many times over
   localparam int IDLE_LIMIT   = 2000;
   // drain time after the last expected beat: one full rescan walk plus margin
   localparam int TAIL_CYCLES  = 60;
   localparam int RANDOM_BEATS = 270;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dscq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dscq_rsp_type rsp_data;

   // request beats still to be sent, filled once at time zero
   dscq_req_type beats_to_send[$];
   // announcements the block owes, oldest first
   dscq_rsp_type announcements_due[$];

   // predicted per-channel state
   logic [7:0]  shown_state[CHANNELS];
   logic [7:0]  held_state[CHANNELS];
   logic [15:0] hold_ticks[CHANNELS];
   logic        seen[CHANNELS];

   int          mismatches = 0;
   int          send_gap   = 0;
   bit          send_calm  = 1'b0;
   bit          holding;
   dscq_req_type sent_beat;
   int          stall_left = 0;
   bit          take_calm  = 1'b0;
   dscq_rsp_type owed;
   int          idle_cycles = 0;

   delayed_state_change_qualifier #(
      .CHANNELS(CHANNELS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // waits per beat: none while calm, so there are stretches at full rate
   function automatic int draw_wait(input bit calm);
      if (calm)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // work out which announcements one accepted request beat causes
   function automatic void qualify_beat(input dscq_req_type beat);
      dscq_rsp_type ann;
      int unsigned  ch;
      int           top;
      bit           do_update;
      bit           do_publish;
      do_update  = 1'b0;
      do_publish = 1'b0;
      if (beat.operation == OP_SAMPLE) begin
         ch = beat.channel;
         // samples for channels the block does not have are dropped
         if (ch >= CHANNELS)
            return;
         if (!seen[ch]) begin
            // first sample of a channel always updates, even at the reset value
            seen[ch]  = 1'b1;
            do_update = 1'b1;
         end else if (hold_ticks[ch] == 16'd0) begin
            do_update = (shown_state[ch] != beat.new_state);
         end else if (held_state[ch] != beat.new_state) begin
            // leaving the pending state restarts the delay
            do_update = 1'b1;
         end else begin
            hold_ticks[ch] = hold_ticks[ch] - 16'd1;
            do_publish     = (hold_ticks[ch] == 16'd0);
         end
         if (do_update) begin
            hold_ticks[ch] = beat.action_delay;
            if (beat.action_delay == 16'd0)
               do_publish = 1'b1;
            else
               held_state[ch] = beat.new_state;
         end
         if (do_publish) begin
            shown_state[ch] = beat.new_state;
            ann.out_channel = ch[3:0];
            ann.out_state   = beat.new_state;
            ann.is_rescan   = 1'b0;
            ann.last        = 1'b1;
            announcements_due.push_back(ann);
         end
      end else begin
         // rescan: ascending channel order, last on the highest selected channel,
         // mask bits beyond the channel count are ignored
         top = -1;
         for (int i = 0; i < CHANNELS; i++)
            if (beat.rescan_mask[i])
               top = i;
         for (int i = 0; i < CHANNELS; i++) begin
            if (beat.rescan_mask[i]) begin
               ann.out_channel = i[3:0];
               ann.out_state   = shown_state[i];
               ann.is_rescan   = 1'b1;
               ann.last        = (i == top);
               announcements_due.push_back(ann);
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // rescan_mask is ignored on a sample, so it gets random bits
   task automatic push_sample(input logic [3:0] ch, input logic [7:0] st,
                              input logic [15:0] dly);
      dscq_req_type beat;
      beat.operation    = OP_SAMPLE;
      beat.channel      = ch;
      beat.new_state    = st;
      beat.action_delay = dly;
      beat.rescan_mask  = 16'($urandom_range(0, 65535));
      beats_to_send.push_back(beat);
   endtask

   // channel, state and delay are ignored on a rescan, so they get random bits
   task automatic push_rescan(input logic [15:0] mask);
      dscq_req_type beat;
      beat.operation    = OP_RESCAN;
      beat.channel      = 4'($urandom_range(0, 15));
      beat.new_state    = 8'($urandom_range(0, 255));
      beat.action_delay = 16'($urandom_range(0, 65535));
      beat.rescan_mask  = mask;
      beats_to_send.push_back(beat);
   endtask

   // request driver: presents the head of the queue, holds it while stalled,
   // then waits a drawn number of cycles before the next beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         for (int i = 0; i < CHANNELS; i++) begin
            shown_state[i] = 8'd0;
            held_state[i]  = 8'd0;
            hold_ticks[i]  = 16'd0;
            seen[i]        = 1'b0;
         end
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            sent_beat = beats_to_send.pop_front();
            qualify_beat(sent_beat);
            send_gap = draw_wait(send_calm);
            if ($urandom_range(0, 39) == 0)
               send_calm = !send_calm;
            holding = 1'b0;
         end
         // a held beat keeps valid and payload untouched
         if (!holding) begin
            if (send_gap == 0 && beats_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= beats_to_send[0];
            end else begin
               if (send_gap > 0)
                  send_gap--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each accepted beat against the oldest owed
   // announcement, then stalls for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (announcements_due.size() == 0) begin
               $error("unexpected response beat: channel %0d state %0d",
                      rsp_data.out_channel, rsp_data.out_state);
               mismatches++;
            end else begin
               owed = announcements_due.pop_front();
               check_field("out_channel", owed.out_channel, rsp_data.out_channel);
               check_field("out_state", owed.out_state, rsp_data.out_state);
               check_field("is_rescan", owed.is_rescan, rsp_data.is_rescan);
               check_field("last", owed.last, rsp_data.last);
            end
            stall_left = draw_wait(take_calm);
            if ($urandom_range(0, 39) == 0)
               take_calm = !take_calm;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0]  ch;
      logic [7:0]  st;
      logic [15:0] dly;
      int          reps;

      // first sample publishes even when it matches the reset value
      push_sample(4'd0, 8'h00, 16'd0);
      // same state again, timer idle: nothing
      push_sample(4'd0, 8'h00, 16'd0);
      push_sample(4'd15, 8'hFF, 16'd0);
      push_sample(4'd15, 8'hFF, 16'hFFFF);
      // longest delay goes pending, then a different state reloads the timer
      push_sample(4'd1, 8'hA5, 16'hFFFF);
      push_sample(4'd1, 8'h5A, 16'd2);
      push_sample(4'd1, 8'h5A, 16'hFFFF);
      push_sample(4'd1, 8'h5A, 16'd0);
      // delay of one publishes on the next matching sample
      push_sample(4'd2, 8'h11, 16'd1);
      push_sample(4'd2, 8'h11, 16'd0);
      push_sample(4'd2, 8'h22, 16'd3);
      // back to the published value while pending still restarts the delay
      push_sample(4'd2, 8'h11, 16'd1);
      push_sample(4'd2, 8'h11, 16'd0);
      // empty rescan gives no beat
      push_rescan(16'h0000);
      push_rescan(16'hFFFF);
      push_rescan(16'h8001);
      push_rescan(16'h5555);
      push_rescan(16'hAAAA);
      push_sample(4'd15, 8'h00, 16'd0);
      push_rescan(16'h8000);

      // random part: mostly runs of matching samples long enough to publish,
      // with broken runs, rescans and fully random beats mixed in
      while (beats_to_send.size() < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 5))
                  0:       push_rescan(16'h0000);
                  1:       push_rescan(16'hFFFF);
                  default: push_rescan(16'($urandom_range(0, 65535)));
               endcase
            end
            1: push_sample(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)));
            default: begin
               ch  = 4'($urandom_range(0, 15));
               st  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 3));
               dly = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 4));
               reps = (dly <= 16'd4) ? dly + $urandom_range(0, 2) : $urandom_range(0, 3);
               push_sample(ch, st, dly);
               for (int r = 0; r < reps; r++) begin
                  // occasionally break the run with a different state
                  if ($urandom_range(0, 7) == 0)
                     push_sample(ch, st + 8'd1, 16'($urandom_range(0, 4)));
                  else
                     push_sample(ch, st, 16'($urandom_range(0, 65535)));
               end
            end
         endcase
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (beats_to_send.size() != 0 || req_valid)
         @(posedge clock);
      while (announcements_due.size() != 0)
         @(posedge clock);
      // stray beats after the last owed one are caught as unexpected
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
